### design/char_range_expander_assert.svh
// Assertion macros for the character range expander checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CHAR_RANGE_EXPANDER_ASSERT_SVH
`define CHAR_RANGE_EXPANDER_ASSERT_SVH

// Same-cycle or overlapping implication, disabled while in reset
`define CRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cre_pkg.sv
// Shared types, character constants and class helpers for the range expander.
// Used by the controller, the datapath and the top level.
`default_nettype none

package cre_pkg;

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;
  localparam logic [7:0] CH_NUL  = 8'h00;
  // distance between the two letter cases
  localparam logic [7:0] CASE_OFS = CH_LA - CH_UA;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_DASH,
    ST_CHAR,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    SRC_RANGE,
    SRC_DASH,
    SRC_CHAR,
    SRC_END
  } src_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // take the input item and update string state
    logic emit;       // load the output register
    src_t src;        // what the output register takes
    logic emit_last;  // result is the final one of its item
    logic k_inc;      // advance the range counter
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pend;        // a dash is waiting for its tail
    logic ok;          // held head and incoming byte form a valid range
    logic nonempty;    // the range emits at least one character
    logic in_last;     // incoming byte ends the string
    logic dash_new;    // incoming byte becomes a held dash
    logic last_r;      // latched item ends the string
    logic dash_new_r;  // latched item left a held dash
    logic k_at_tail;   // range counter has reached the tail
    logic slot_free;   // output register can take a result this cycle
  } sts_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LA) && (c <= CH_LZ);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UA) && (c <= CH_UZ);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

endpackage

`default_nettype wire

### design/cre_datapath.sv
// Datapath of the range expander: string state, range counter, output register.
// Depends on cre_pkg; driven by cre_ctrl through cmd_t, reports through sts_t.
`default_nettype none

module cre_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_char,
  input  wire logic          in_last,
  input  wire logic          out_stall,
  input  wire cre_pkg::cmd_t cmd,
  output cre_pkg::sts_t      sts,
  output logic               out_valid,
  output logic [7:0]         out_char,
  output logic               out_is_end,
  output logic               out_last
);
  import cre_pkg::*;

  logic [7:0] prev_r, prev_nxt;
  logic       pend_r, pend_nxt;
  logic       start_r;
  logic [7:0] c_r;
  logic       last_r;
  logic       dash_new_r;
  logic [7:0] k_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_is_end_r;
  logic       out_last_r;

  logic [7:0] head_cv;
  logic       range_ok;
  logic       dash_new;

  // convert the head to the tail's case, then test the range
  always_comb begin
    head_cv = prev_r;
    if (is_lower(prev_r) && is_upper(in_char)) begin
      head_cv = prev_r - CASE_OFS;
    end else if (is_upper(prev_r) && is_lower(in_char)) begin
      head_cv = prev_r + CASE_OFS;
    end
    range_ok = (head_cv <= in_char) &&
               ((is_lower(head_cv) && is_lower(in_char)) ||
                (is_upper(head_cv) && is_upper(in_char)) ||
                (is_digit(head_cv) && is_digit(in_char)));
    // after a rejected dash the byte is never at the start of the string
    dash_new = (in_char == CH_DASH) && !in_last && (pend_r || !start_r);
  end

  // work out the string state that the item leaves behind
  always_comb begin
    prev_nxt = in_char;
    pend_nxt = dash_new;
    if (pend_r && range_ok) begin
      pend_nxt = 1'b0;
    end else if (dash_new) begin
      prev_nxt = pend_r ? CH_DASH : prev_r;
    end
  end

  // string state; the end of a string returns it to reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= CH_NUL;
      pend_r  <= 1'b0;
      start_r <= 1'b1;
    end else if (cmd.load) begin
      if (in_last) begin
        prev_r  <= CH_NUL;
        pend_r  <= 1'b0;
        start_r <= 1'b1;
      end else begin
        prev_r  <= prev_nxt;
        pend_r  <= pend_nxt;
        start_r <= 1'b0;
      end
    end
  end

  // latch the item and seed the range counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r        <= in_char;
      last_r     <= in_last;
      dash_new_r <= dash_new;
      k_r        <= head_cv + 8'd1;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 8'd1;
    end
  end

  // output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= cmd.emit_last;
      case (cmd.src)
        SRC_RANGE: begin
          out_char_r   <= k_r;
          out_is_end_r <= 1'b0;
        end
        SRC_DASH: begin
          out_char_r   <= CH_DASH;
          out_is_end_r <= 1'b0;
        end
        SRC_CHAR: begin
          out_char_r   <= c_r;
          out_is_end_r <= 1'b0;
        end
        default: begin
          out_char_r   <= CH_NUL;
          out_is_end_r <= 1'b1;
        end
      endcase
    end
  end

  // status back to the controller
  always_comb begin
    sts.pend       = pend_r;
    sts.ok         = range_ok;
    sts.nonempty   = head_cv < in_char;
    sts.in_last    = in_last;
    sts.dash_new   = dash_new;
    sts.last_r     = last_r;
    sts.dash_new_r = dash_new_r;
    sts.k_at_tail  = (k_r == c_r);
    sts.slot_free  = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_is_end = out_is_end_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

### design/cre_ctrl.sv
// Controller of the range expander: sequences the results of one item.
// Depends on cre_pkg; commands cre_datapath through cmd_t.
`default_nettype none

module cre_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cre_pkg::sts_t sts,
  output cre_pkg::cmd_t      cmd
);
  import cre_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = (state_r == ST_IDLE) && in_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sts.pend) begin
            if (!sts.ok) begin
              state_nxt = ST_DASH;
            end else if (sts.nonempty) begin
              state_nxt = ST_RANGE;
            end else if (sts.in_last) begin
              state_nxt = ST_END;
            end
          end else if (!sts.dash_new) begin
            state_nxt = ST_CHAR;
          end
        end
      end
      ST_RANGE: begin
        if (sts.slot_free && sts.k_at_tail) begin
          state_nxt = sts.last_r ? ST_END : ST_IDLE;
        end
      end
      ST_DASH: begin
        if (sts.slot_free) begin
          state_nxt = sts.dash_new_r ? ST_IDLE : ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (sts.slot_free) begin
          state_nxt = sts.last_r ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    cmd.load      = accept;
    cmd.emit      = 1'b0;
    cmd.src       = SRC_END;
    cmd.emit_last = 1'b1;
    cmd.k_inc     = 1'b0;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.emit = 1'b0;
      end
      ST_RANGE: begin
        cmd.emit      = sts.slot_free;
        cmd.src       = SRC_RANGE;
        cmd.emit_last = sts.k_at_tail && !sts.last_r;
        cmd.k_inc     = sts.slot_free;
      end
      ST_DASH: begin
        cmd.emit      = sts.slot_free;
        cmd.src       = SRC_DASH;
        cmd.emit_last = sts.dash_new_r;
      end
      ST_CHAR: begin
        cmd.emit      = sts.slot_free;
        cmd.src       = SRC_CHAR;
        cmd.emit_last = !sts.last_r;
      end
      ST_END: begin
        cmd.emit      = sts.slot_free;
        cmd.src       = SRC_END;
        cmd.emit_last = 1'b1;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/char_range_expander.sv
// Character range expander: takes a string a byte at a time and writes it out
// with shorthand such as a-e expanded to the characters after the head. Each
// input item is taken in the idle state; the item then produces its results one
// per cycle, when the output is not stalled, through a single output register.
// The longest item, a full letter range ending the string, gives 26 results.
// An item that only holds a dash gives no result and the next item may follow
// in the very next cycle. The input stalls while an item's results are still
// being produced; the last result of an item may wait in the output register
// while the next item is taken. Depends on cre_pkg, cre_ctrl and cre_datapath.
`default_nettype none

module char_range_expander (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_is_end,
  output logic            out_last
);
  import cre_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence the results of each item
  cre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold string state and build each result
  cre_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_char),
    .in_last    (in_last),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_char   (out_char),
    .out_is_end (out_is_end),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

### design/cre_checker.sv
// Port-level checks for the character range expander, bound to the top level.
// Depends on char_range_expander_assert.svh for the assertion macros.
`default_nettype none

module cre_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_is_end,
  input wire logic       out_last
);

`include "char_range_expander_assert.svh"

  // a held result keeps its payload
  `CRE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(out_last), "stalled result changed")

  // the terminator carries no character and closes its item
  `CRE_ASSERT_NOW(a_end_form, out_valid && out_is_end, out_last && (out_char == 8'h00), "malformed terminator")

  // the end of a string always leaves at least the terminator to produce
  `CRE_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_last, in_stall, "string end not followed by results")

  // no new item while the current one still has results to come
  `CRE_ASSERT_NOW(a_no_overlap, out_valid && !out_last, in_stall, "item taken mid-sequence")

endmodule

bind char_range_expander cre_checker u_cre_checker (.*);

`default_nettype wire
